FILE: rtl/core/sdf_pkg.sv
package sdf_pkg;

   // Frame limits and field widths
   localparam int unsigned MaxPayload = 1023;
   localparam int unsigned LenW       = 10;
   localparam int unsigned CrcW       = 32;

   // Upper six bits of the second sync byte are compared
   localparam logic [7:0] SYNC_MASK = 8'hFC;

   // Command queue between front and back
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
   localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

   typedef enum logic [2:0] {
      PH_SYNC1,
      PH_SYNC2,
      PH_LENGTH,
      PH_TYPE,
      PH_PAYLOAD,
      PH_CRC
   } phase_type;

   typedef enum logic [2:0] {
      OP_START,    // load CRC from initial value, then fold byte
      OP_UPDATE,   // fold byte into CRC
      OP_PAYLOAD,  // fold byte and emit it
      OP_SHIFT,    // collect one received CRC byte
      OP_CHECK     // last CRC byte: compare and emit status
   } op_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CSR_SYNC_FIRST  = 2'd0,
      CSR_SYNC_SECOND = 2'd1,
      CSR_CRC_POLY    = 2'd2,
      CSR_CRC_INIT    = 2'd3
   } csr_index_type;

   typedef struct packed {
      op_type            op;
      logic [7:0]        data;
      logic [LenW-1:0]   index;
      logic [7:0]        frame_type;
   } cmd_type;

   typedef struct packed {
      logic [7:0] first;
      logic [7:0] second;
   } sync_cfg_type;

   typedef struct packed {
      logic [CrcW-1:0] poly;
      logic [CrcW-1:0] init;
   } crc_cfg_type;

   // MSB-first CRC update over one byte
   function automatic logic [CrcW-1:0] crc_step(input logic [CrcW-1:0] crc,
                                                input logic [7:0]      data,
                                                input logic [CrcW-1:0] poly);
      logic [CrcW-1:0] x;
      x = crc ^ {data, {(CrcW-8){1'b0}}};
      for (int i = 0; i < 8; i++) begin
         if (x[CrcW-1]) begin
            x = {x[CrcW-2:0], 1'b0} ^ poly;
         end else begin
            x = {x[CrcW-2:0], 1'b0};
         end
      end
      return x;
   endfunction

endpackage

FILE: rtl/core/sdf_req_if.sv
interface sdf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       end_of_chunk;

   modport source (output valid, output rx_byte, output end_of_chunk, input ready);
   modport sink   (input valid, input rx_byte, input end_of_chunk, output ready);
endinterface

FILE: rtl/core/sdf_rsp_if.sv
interface sdf_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] payload_byte;
   logic [9:0] payload_index;
   logic [7:0] frame_type;
   logic       frame_done;

   modport source (output valid, output result_kind, output payload_byte,
                   output payload_index, output frame_type, output frame_done,
                   input ready);
   modport sink   (input valid, input result_kind, input payload_byte,
                   input payload_index, input frame_type, input frame_done,
                   output ready);
endinterface

FILE: rtl/core/sdf_front.sv
module sdf_front (
   input  logic                  clock,
   input  logic                  reset,
   sdf_req_if.sink               req_chan,
   input  sdf_pkg::sync_cfg_type sync_cfg,
   input  logic                  queue_full,
   output logic                  cmd_push,
   output sdf_pkg::cmd_type      cmd
);

   sdf_pkg::phase_type             phase_ff, phase_in;
   logic [sdf_pkg::LenW-1:0]       len_ff, len_in;
   logic [sdf_pkg::LenW-1:0]       cnt_ff, cnt_in;
   logic [7:0]                     type_ff, type_in;
   logic [1:0]                     crc_cnt_ff, crc_cnt_in;
   logic                           accept;
   logic                           first_hit;
   logic                           second_hit;
   logic                           last_payload;
   logic [sdf_pkg::LenW:0]         cnt_next;
   logic [7:0]                     b;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && !queue_full;
   assign b              = req_chan.rx_byte;

   assign first_hit    = (b == sync_cfg.first);
   assign second_hit   = ((b & sdf_pkg::SYNC_MASK) == (sync_cfg.second & sdf_pkg::SYNC_MASK));
   assign cnt_next     = {1'b0, cnt_ff} + {{sdf_pkg::LenW{1'b0}}, 1'b1};
   assign last_payload = (cnt_next >= {1'b0, len_ff});

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            sdf_pkg::PH_SYNC1: begin
               phase_in = first_hit ? sdf_pkg::PH_SYNC2 : sdf_pkg::PH_SYNC1;
            end
            sdf_pkg::PH_SYNC2: begin
               if (second_hit) begin
                  phase_in = sdf_pkg::PH_LENGTH;
               end else if (first_hit) begin
                  phase_in = sdf_pkg::PH_SYNC2;
               end else begin
                  phase_in = sdf_pkg::PH_SYNC1;
               end
            end
            sdf_pkg::PH_LENGTH: phase_in = sdf_pkg::PH_TYPE;
            sdf_pkg::PH_TYPE: begin
               if (len_ff > sdf_pkg::LenW'(sdf_pkg::MaxPayload)) begin
                  phase_in = sdf_pkg::PH_SYNC1;
               end else if (len_ff == '0) begin
                  phase_in = sdf_pkg::PH_CRC;
               end else begin
                  phase_in = sdf_pkg::PH_PAYLOAD;
               end
            end
            sdf_pkg::PH_PAYLOAD: begin
               phase_in = last_payload ? sdf_pkg::PH_CRC : sdf_pkg::PH_PAYLOAD;
            end
            sdf_pkg::PH_CRC: begin
               phase_in = (crc_cnt_ff == 2'd3) ? sdf_pkg::PH_SYNC1 : sdf_pkg::PH_CRC;
            end
            default: phase_in = sdf_pkg::PH_SYNC1;
         endcase
         // Drop an unfinished frame at the end of a chunk
         if (req_chan.end_of_chunk) begin
            phase_in = sdf_pkg::PH_SYNC1;
         end
      end
   end

   // Commands and frame fields
   always_comb begin
      cmd_push        = 1'b0;
      cmd.op          = sdf_pkg::OP_UPDATE;
      cmd.data        = b;
      cmd.index       = cnt_ff;
      cmd.frame_type  = type_ff;
      len_in          = len_ff;
      cnt_in          = cnt_ff;
      type_in         = type_ff;
      crc_cnt_in      = crc_cnt_ff;
      case (phase_ff)
         sdf_pkg::PH_SYNC1: begin
            cmd_push = accept && first_hit;
            cmd.op   = sdf_pkg::OP_START;
         end
         sdf_pkg::PH_SYNC2: begin
            cmd_push = accept && (second_hit || first_hit);
            cmd.op   = second_hit ? sdf_pkg::OP_UPDATE : sdf_pkg::OP_START;
            if (accept && second_hit) begin
               len_in = {b[1:0], 8'h00};
            end
         end
         sdf_pkg::PH_LENGTH: begin
            cmd_push = accept;
            if (accept) begin
               len_in = {len_ff[sdf_pkg::LenW-1:8], b};
            end
         end
         sdf_pkg::PH_TYPE: begin
            cmd_push = accept;
            if (accept) begin
               type_in    = b;
               cnt_in     = '0;
               crc_cnt_in = '0;
            end
         end
         sdf_pkg::PH_PAYLOAD: begin
            cmd_push = accept;
            cmd.op   = sdf_pkg::OP_PAYLOAD;
            if (accept) begin
               cnt_in = cnt_next[sdf_pkg::LenW-1:0];
            end
         end
         sdf_pkg::PH_CRC: begin
            cmd_push = accept;
            cmd.op   = (crc_cnt_ff == 2'd3) ? sdf_pkg::OP_CHECK : sdf_pkg::OP_SHIFT;
            if (accept) begin
               crc_cnt_in = crc_cnt_ff + 2'd1;
            end
         end
         default: cmd_push = 1'b0;
      endcase
      if (accept && req_chan.end_of_chunk) begin
         crc_cnt_in = '0;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= sdf_pkg::PH_SYNC1;
         crc_cnt_ff <= '0;
         len_ff     <= '0;
         cnt_ff     <= '0;
         type_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         crc_cnt_ff <= crc_cnt_in;
         len_ff     <= len_in;
         cnt_ff     <= cnt_in;
         type_ff    <= type_in;
      end
   end

   a_payload_len: assert property (@(posedge clock) disable iff (reset)
      phase_ff == sdf_pkg::PH_PAYLOAD |-> (len_ff != '0 && cnt_ff < len_ff))
      else $error("payload phase with count out of range");

   a_crc_cnt: assert property (@(posedge clock) disable iff (reset)
      phase_ff != sdf_pkg::PH_CRC |-> crc_cnt_ff == '0)
      else $error("CRC byte count left over outside CRC phase");

endmodule

FILE: rtl/core/sdf_queue.sv
module sdf_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sdf_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output sdf_pkg::cmd_type head_cmd
);

   sdf_pkg::cmd_type                 entry_ff [sdf_pkg::QueueDepth];
   logic [sdf_pkg::QueuePtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [sdf_pkg::QueuePtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [sdf_pkg::QueueCntW-1:0]    count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   assign full       = (count_ff == sdf_pkg::QueueCntW'(sdf_pkg::QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed command
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command pushed into full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sdf_pkg::QueueCntW'(sdf_pkg::QueueDepth))
      else $error("queue occupancy above depth");

endmodule

FILE: rtl/core/sdf_back.sv
module sdf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  sdf_pkg::crc_cfg_type crc_cfg,
   input  logic                 head_valid,
   input  sdf_pkg::cmd_type     head_cmd,
   output logic                 pop,
   sdf_rsp_if.source            rsp_chan
);

   logic [sdf_pkg::CrcW-1:0]   crc_ff, crc_in;
   logic [sdf_pkg::CrcW-9:0]   rx_crc_ff, rx_crc_in;
   logic                       out_valid_ff, out_valid_in;
   sdf_pkg::kind_type          kind_ff, kind_in;
   logic [7:0]                 byte_ff, byte_in;
   logic [sdf_pkg::LenW-1:0]   index_ff, index_in;
   logic [7:0]                 type_ff, type_in;
   logic                       done_ff, done_in;
   logic                       slot_free;
   logic [sdf_pkg::CrcW-1:0]   crc_base;

   assign slot_free = !out_valid_ff || rsp_chan.ready;
   assign pop       = head_valid && slot_free;
   assign crc_base  = (head_cmd.op == sdf_pkg::OP_START) ? crc_cfg.init : crc_ff;

   // Execute the head command
   always_comb begin
      crc_in       = crc_ff;
      rx_crc_in    = rx_crc_ff;
      out_valid_in = out_valid_ff;
      kind_in      = kind_ff;
      byte_in      = byte_ff;
      index_in     = index_ff;
      type_in      = type_ff;
      done_in      = done_ff;
      if (slot_free) begin
         out_valid_in = 1'b0;
      end
      if (pop) begin
         case (head_cmd.op)
            sdf_pkg::OP_START,
            sdf_pkg::OP_UPDATE: begin
               crc_in = sdf_pkg::crc_step(crc_base, head_cmd.data, crc_cfg.poly);
            end
            sdf_pkg::OP_PAYLOAD: begin
               crc_in       = sdf_pkg::crc_step(crc_base, head_cmd.data, crc_cfg.poly);
               out_valid_in = 1'b1;
               kind_in      = sdf_pkg::KIND_PAYLOAD;
               byte_in      = head_cmd.data;
               index_in     = head_cmd.index;
               type_in      = head_cmd.frame_type;
               done_in      = 1'b0;
            end
            sdf_pkg::OP_SHIFT: begin
               rx_crc_in = {rx_crc_ff[sdf_pkg::CrcW-17:0], head_cmd.data};
            end
            sdf_pkg::OP_CHECK: begin
               out_valid_in = 1'b1;
               kind_in      = ({rx_crc_ff, head_cmd.data} == crc_ff) ?
                              sdf_pkg::KIND_GOOD : sdf_pkg::KIND_ERROR;
               byte_in      = '0;
               index_in     = '0;
               type_in      = head_cmd.frame_type;
               done_in      = 1'b1;
            end
            default: crc_in = crc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold datapath and result fields
   always_ff @(posedge clock) begin
      crc_ff    <= crc_in;
      rx_crc_ff <= rx_crc_in;
      kind_ff   <= kind_in;
      byte_ff   <= byte_in;
      index_ff  <= index_in;
      type_ff   <= type_in;
      done_ff   <= done_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.result_kind   = kind_ff;
   assign rsp_chan.payload_byte  = byte_ff;
   assign rsp_chan.payload_index = index_ff;
   assign rsp_chan.frame_type    = type_ff;
   assign rsp_chan.frame_done    = done_ff;

   a_pop_slot: assert property (@(posedge clock) disable iff (reset)
      pop |-> (!out_valid_ff || rsp_chan.ready))
      else $error("command executed while result slot occupied");

   a_done_kind: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (done_ff == (kind_ff != sdf_pkg::KIND_PAYLOAD)))
      else $error("frame_done disagrees with result kind");

endmodule

FILE: rtl/core/sync_length_crc32_deframer_core.sv
// Channel   Dir   Fields                                                    Handshake
// req_chan  in    rx_byte[7:0], end_of_chunk                                valid/ready
// rsp_chan  out   result_kind[1:0], payload_byte[7:0], payload_index[9:0],  valid/ready
//                 frame_type[7:0], frame_done
// csr       in    csr_index[1:0], csr_wdata[31:0]                           csr_we
//
// One byte per cycle while the queue is not full; a result is registered after the queue.
// The front FSM classifies each byte into a command; a 4-entry queue feeds the back,
// which folds a byte per cycle into the CRC in one unrolled step unless rsp_chan stalls.
// req_chan.ready drops only when the queue is full, i.e. after rsp_chan stalls.
// Synchronous active-high reset of control and CSR state; the datapath is not reset.
module sync_length_crc32_deframer_core (
   input  logic        clock,
   input  logic        reset,
   sdf_req_if.sink     req_chan,
   sdf_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   sdf_pkg::sync_cfg_type sync_cfg_ff;
   sdf_pkg::crc_cfg_type  crc_cfg_ff;
   sdf_pkg::cmd_type      push_cmd;
   sdf_pkg::cmd_type      head_cmd;
   logic                  push;
   logic                  full;
   logic                  pop;
   logic                  head_valid;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_cfg_ff.first  <= 8'h00;
         sync_cfg_ff.second <= 8'h00;
         crc_cfg_ff.poly    <= 32'h04C11DB7;
         crc_cfg_ff.init    <= 32'hFFFFFFFF;
      end else if (csr_we) begin
         case (sdf_pkg::csr_index_type'(csr_index))
            sdf_pkg::CSR_SYNC_FIRST:  sync_cfg_ff.first  <= csr_wdata[7:0];
            sdf_pkg::CSR_SYNC_SECOND: sync_cfg_ff.second <= csr_wdata[7:0];
            sdf_pkg::CSR_CRC_POLY:    crc_cfg_ff.poly    <= csr_wdata;
            sdf_pkg::CSR_CRC_INIT:    crc_cfg_ff.init    <= csr_wdata;
            default:                  crc_cfg_ff.init    <= crc_cfg_ff.init;
         endcase
      end
   end

   sdf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .sync_cfg   (sync_cfg_ff),
      .queue_full (full),
      .cmd_push   (push),
      .cmd        (push_cmd)
   );

   sdf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   sdf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .crc_cfg    (crc_cfg_ff),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
